// ----- sv/adcss_pkg.sv -----
// ----------------------------------------------------------------------------
// adcss_pkg
// Shared widths, constants, lookup functions and divider interface types for
// the ADC sample scaler.
// ----------------------------------------------------------------------------
package adcss_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int V_W       = 13;
    localparam int QUANT_W   = 16;
    localparam int ACC_W     = 18;
    localparam int SUM_W     = 29;
    localparam int CNT_W     = 17;
    localparam int OUT_W     = 25;
    localparam int OPD_W     = 29;
    localparam int MAG_W     = SUM_W;
    localparam int PROD_W    = OPD_W + QUANT_W;
    localparam int STEP_W    = $clog2(MAG_W + 1);
    localparam int CFG_IDX_W = 3;
    localparam int RECIP_W   = 32;
    localparam int TEN_SH    = 35;

    localparam logic [CNT_W-1:0]        MAX_POINTS = 17'd65536;
    localparam logic [CNT_W-1:0]        PTS_RESET  = 17'd1024;
    localparam logic signed [ACC_W-1:0] MIN_INIT   = 18'sd99999;
    localparam logic signed [ACC_W-1:0] MAX_INIT   = -18'sd99999;
    // ceil(2^35 / 10): exact floor divide by ten for any 32-bit magnitude
    localparam logic [RECIP_W-1:0]      RECIP_TEN  = 32'hCCCC_CCCD;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHIFT_A  = 3'd0,
        CFG_RANGE_A  = 3'd1,
        CFG_SHIFT_B  = 3'd2,
        CFG_RANGE_B  = 3'd3,
        CFG_STATS_EN = 3'd4,
        CFG_POINTS   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dvd;
        logic [CNT_W-1:0] dvs;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quo;
    } t_div_rsp;

    function automatic logic signed [V_W-1:0] offset_of(input logic [1:0] code);
        logic signed [V_W-1:0] off;
        case (code)
            2'd1:    off = 13'sd1024;
            2'd2:    off = 13'sd3072;
            default: off = 13'sd2048;
        endcase
        return off;
    endfunction

    function automatic logic [QUANT_W-1:0] quant_of(input logic [1:0] code);
        logic [QUANT_W-1:0] q;
        case (code)
            2'd0:    q = 16'd39072;
            2'd1:    q = 16'd19536;
            2'd2:    q = 16'd9768;
            default: q = 16'd4884;
        endcase
        return q;
    endfunction

endpackage

// ----- sv/adc_sample_scaler_with_stats.sv -----
// ----------------------------------------------------------------------------
// adc_sample_scaler_with_stats
// Removes the channel offset from raw ADC codes, scales by the channel
// quantum over ten, and keeps per-record min, max and sum statistics.
// An accepted item passes the quantum multiply, the reciprocal multiply for
// the divide by ten and the output register; the next item is taken only
// once the result is pushed. Record end with stats on: three more multiply
// pairs (min, max, then average) and a 29-step average division before the
// average pair. A stalled output holds the sequencer in its push state.
// Reset (synchronous, active low) clears the sequencer, the accumulators and
// the output valid, and loads the register defaults (record length 1024).
// ----------------------------------------------------------------------------
module adc_sample_scaler_with_stats import adcss_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [SAMPLE_W-1:0]     i_raw_sample,
    input  logic                    i_channel,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [OUT_W-1:0] o_scaled_value,
    output logic                    o_record_done,
    output logic signed [OUT_W-1:0] o_stat_min,
    output logic signed [OUT_W-1:0] o_stat_max,
    output logic signed [OUT_W-1:0] o_stat_avg,
    output logic signed [SUM_W-1:0] o_stat_integral,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CNT_W-1:0]        i_cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_TEN, S_DGO, S_DWAIT, S_PUSH} t_state;
    typedef enum logic [2:0] {OP_VAL, OP_MIN, OP_MAX, OP_SUM, OP_AVG} t_op;

    // configuration
    logic [1:0]       r_shift_a, r_range_a, r_shift_b, r_range_b;
    logic             r_stats_en;
    logic [CNT_W-1:0] r_points;

    // accumulators
    logic [CNT_W-1:0]        r_count;
    logic signed [ACC_W-1:0] r_min, r_max;
    logic signed [SUM_W-1:0] r_sum;

    // sequencer and work registers
    t_state                  r_state;
    t_op                     r_op;
    logic signed [V_W-1:0]   r_v;
    logic [QUANT_W-1:0]      r_quant;
    logic                    r_done;
    logic                    r_stats;
    logic signed [ACC_W-1:0] r_smin, r_smax;
    logic signed [SUM_W-1:0] r_ssum;
    logic signed [OPD_W-1:0] r_q;
    logic [RECIP_W-1:0]      r_prod;
    logic [MAG_W-1:0]        r_dvd;
    logic [CNT_W-1:0]        r_dvs;
    logic                    r_neg;
    logic signed [OUT_W-1:0] r_w_scaled, r_w_min, r_w_max, r_w_avg;

    // output register
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_o_scaled, r_o_min, r_o_max, r_o_avg;
    logic                    r_o_done;
    logic signed [SUM_W-1:0] r_o_integral;

    logic                    w_accept;
    logic                    w_push;
    logic [1:0]              w_sh, w_rg;
    logic signed [V_W-1:0]   w_v;
    logic signed [ACC_W-1:0] w_v_ext;
    logic signed [ACC_W-1:0] n_min, n_max;
    logic signed [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0]        n_count;
    logic [CNT_W-1:0]        w_npts;
    logic                    w_rec_end;
    logic signed [OPD_W-1:0] w_opd;
    logic [OPD_W-1:0]        w_opd_mag;
    logic [PROD_W-1:0]       w_prod;
    logic [2*RECIP_W-1:0]    w_ten_prod;
    logic [OPD_W-1:0]        w_ten_mag;
    logic [OPD_W-1:0]        w_ten_s;
    logic [SUM_W-1:0]        w_sum_mag;
    logic [MAG_W-1:0]        w_quo_s;
    t_div_req                w_div_req;
    t_div_rsp                w_div_rsp;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_push      = (r_state == S_PUSH) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_a  <= '0;
            r_range_a  <= '0;
            r_shift_b  <= '0;
            r_range_b  <= '0;
            r_stats_en <= 1'b0;
            r_points   <= PTS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SHIFT_A:  r_shift_a  <= i_cfg_data[1:0];
                CFG_RANGE_A:  r_range_a  <= i_cfg_data[1:0];
                CFG_SHIFT_B:  r_shift_b  <= i_cfg_data[1:0];
                CFG_RANGE_B:  r_range_b  <= i_cfg_data[1:0];
                CFG_STATS_EN: r_stats_en <= i_cfg_data[0];
                CFG_POINTS:   r_points   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_sh      = i_channel ? r_shift_b : r_shift_a;
        w_rg      = i_channel ? r_range_b : r_range_a;
        w_v       = $signed({1'b0, i_raw_sample}) - offset_of(w_sh);
        w_v_ext   = {{(ACC_W-V_W){w_v[V_W-1]}}, w_v};
        n_min     = (w_v_ext < r_min) ? w_v_ext : r_min;
        n_max     = (w_v_ext > r_max) ? w_v_ext : r_max;
        n_sum     = r_sum + {{(SUM_W-V_W){w_v[V_W-1]}}, w_v};
        n_count   = (r_count < MAX_POINTS) ? r_count + 1'b1 : r_count;
        if (r_points == '0) begin
            w_npts = CNT_W'(1);
        end else if (r_points > MAX_POINTS) begin
            w_npts = MAX_POINTS;
        end else begin
            w_npts = r_points;
        end
        w_rec_end = (n_count >= w_npts);
    end

    always_comb begin
        case (r_op)
            OP_MIN:  w_opd = {{(OPD_W-ACC_W){r_smin[ACC_W-1]}}, r_smin};
            OP_MAX:  w_opd = {{(OPD_W-ACC_W){r_smax[ACC_W-1]}}, r_smax};
            OP_AVG:  w_opd = r_q;
            default: w_opd = {{(OPD_W-V_W){r_v[V_W-1]}}, r_v};
        endcase
        w_opd_mag  = w_opd[OPD_W-1] ? (~w_opd + 1'b1) : w_opd;
        w_prod     = w_opd_mag * r_quant;
        w_ten_prod = r_prod * RECIP_TEN;
        w_ten_mag  = w_ten_prod[TEN_SH +: OPD_W];
        w_ten_s    = r_neg ? (~w_ten_mag + 1'b1) : w_ten_mag;
        w_sum_mag  = r_ssum[SUM_W-1] ? (~r_ssum + 1'b1) : r_ssum;
        w_quo_s    = r_neg ? (~w_div_rsp.quo + 1'b1) : w_div_rsp.quo;
    end

    assign w_div_req.start = (r_state == S_DGO);
    assign w_div_req.dvd   = r_dvd;
    assign w_div_req.dvs   = r_dvs;

    adcss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_VAL;
            r_count     <= '0;
            r_min       <= MIN_INIT;
            r_max       <= MAX_INIT;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= OP_VAL;
                        r_state <= S_MUL;
                        if (w_rec_end) begin
                            r_count <= '0;
                            r_min   <= MIN_INIT;
                            r_max   <= MAX_INIT;
                            r_sum   <= '0;
                        end else begin
                            r_count <= n_count;
                            r_min   <= n_min;
                            r_max   <= n_max;
                            r_sum   <= n_sum;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_TEN;
                end
                S_TEN: begin
                    case (r_op)
                        OP_VAL: begin
                            r_op    <= OP_MIN;
                            r_state <= r_stats ? S_MUL : S_PUSH;
                        end
                        OP_MIN: begin
                            r_op    <= OP_MAX;
                            r_state <= S_MUL;
                        end
                        OP_MAX: begin
                            r_op    <= OP_SUM;
                            r_state <= S_DGO;
                        end
                        default: begin
                            r_state <= S_PUSH;
                        end
                    endcase
                end
                S_DGO: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_rsp.done) begin
                        r_op    <= OP_AVG;
                        r_state <= S_MUL;
                    end
                end
                S_PUSH: begin
                    if (w_push) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // work and output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_v     <= w_v;
            r_quant <= quant_of(w_rg);
            r_done  <= w_rec_end;
            r_stats <= w_rec_end && r_stats_en;
            r_smin  <= n_min;
            r_smax  <= n_max;
            r_ssum  <= n_sum;
        end
        if (r_state == S_MUL) begin
            r_prod <= w_prod[RECIP_W-1:0];
            r_neg  <= w_opd[OPD_W-1];
        end
        if (r_state == S_TEN) begin
            case (r_op)
                OP_VAL: r_w_scaled <= w_ten_s[OUT_W-1:0];
                OP_MIN: r_w_min    <= w_ten_s[OUT_W-1:0];
                OP_MAX: begin
                    r_w_max <= w_ten_s[OUT_W-1:0];
                    r_dvd   <= w_sum_mag;
                    r_dvs   <= w_npts;
                    r_neg   <= r_ssum[SUM_W-1];
                end
                default: r_w_avg <= w_ten_s[OUT_W-1:0];
            endcase
        end
        if (r_state == S_DWAIT && w_div_rsp.done) begin
            r_q <= w_quo_s[OPD_W-1:0];
        end
        if (w_push) begin
            r_o_scaled   <= r_w_scaled;
            r_o_done     <= r_done;
            r_o_min      <= r_stats ? r_w_min : '0;
            r_o_max      <= r_stats ? r_w_max : '0;
            r_o_avg      <= r_stats ? r_w_avg : '0;
            r_o_integral <= r_stats ? r_ssum  : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_scaled_value  = r_o_scaled;
    assign o_record_done   = r_o_done;
    assign o_stat_min      = r_o_min;
    assign o_stat_max      = r_o_max;
    assign o_stat_avg      = r_o_avg;
    assign o_stat_integral = r_o_integral;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("item accepted while previous still in work");

    a_stats_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_record_done |->
            o_stat_min == '0 && o_stat_max == '0 && o_stat_avg == '0
            && o_stat_integral == '0)
        else $error("stats reported outside record end");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> r_state == S_DWAIT)
        else $error("divider result outside wait state");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_POINTS)
        else $error("sample count beyond record limit");

endmodule

// ----- sv/adcss_div.sv -----
// ----------------------------------------------------------------------------
// adcss_div
// Restoring unsigned divider, one quotient bit per cycle over the full
// dividend width. Used by the record-average path.
// ----------------------------------------------------------------------------
module adcss_div import adcss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [MAG_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_dvs;
    logic [CNT_W-1:0]  r_rem;
    logic [MAG_W-1:0]  r_quo;

    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_dvd[MAG_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dvd;
            r_dvs <= i_req.dvs;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[MAG_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_quo <= {r_quo[MAG_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && r_cnt == '0)
        else $error("divider done while still stepping");

endmodule
